[hdl/tpaf_pkg.sv]
// Shared types, constants and helpers of the two-port ARQ forwarder.
package tpaf_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	localparam int THR_W = 17;
	localparam logic [THR_W-1:0] THRESHOLD_RESET = 17'd32768;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [FILL_W-1:0] fill_t;

	typedef enum logic [1:0] {
		OP_DATA  = 2'd0,
		OP_ACK   = 2'd1,
		OP_NACK  = 2'd2,
		OP_ROUTE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_ACK  = 2'd1,
		KIND_NACK = 2'd2,
		KIND_DROP = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		CMD_NACK_REPLY,
		CMD_ACK_ROUTE,
		CMD_ROUTE,
		CMD_POP,
		CMD_RESEND
	} cmd_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_SECOND
	} back_state_t;

	typedef struct packed {
		logic [15:0] tag;
		logic [7:0]  errors;
		logic [7:0]  hops;
	} entry_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic       arrival_port;
		logic       route_port;
		logic [1:0] busy;
		entry_t     pkt;
	} cmd_t;

	typedef struct packed {
		logic   port;
		kind_t  kind;
		entry_t data;
		logic   last;
	} result_t;

	function automatic logic [7:0] sat_inc(input logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

endpackage

[hdl/tpaf_front.sv]
// Front end: holds the route threshold, accepts items and classifies them into commands.
module tpaf_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [tpaf_pkg::THR_W-1:0] cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 operation,
	input  logic                       arrival_port,
	input  logic                       bit_error,
	input  logic [15:0]                route_draw,
	input  logic                       busy_port_zero,
	input  logic                       busy_port_one,
	input  logic [15:0]                packet_tag,
	input  logic [7:0]                 packet_errors,
	input  logic [7:0]                 packet_hops,
	output logic                       cmd_valid,
	input  logic                       cmd_ready,
	output tpaf_pkg::cmd_t             cmd
);

	logic [tpaf_pkg::THR_W-1:0] threshold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= tpaf_pkg::THRESHOLD_RESET;
		end else if (cfg_wr_en) begin
			threshold_q <= cfg_wr_data;
		end
	end

	assign in_ready  = cmd_ready;
	assign cmd_valid = in_valid;

	always_comb begin
		cmd.arrival_port = arrival_port;
		cmd.route_port   = ({1'b0, route_draw} < threshold_q) ? 1'b0 : 1'b1;
		cmd.busy         = {busy_port_one, busy_port_zero};
		cmd.pkt.tag      = packet_tag;
		cmd.pkt.errors   = packet_errors;
		cmd.pkt.hops     = packet_hops;
		case (tpaf_pkg::op_t'(operation))
			tpaf_pkg::OP_DATA: begin
				cmd.kind = bit_error ? tpaf_pkg::CMD_NACK_REPLY : tpaf_pkg::CMD_ACK_ROUTE;
			end
			tpaf_pkg::OP_ACK:   cmd.kind = tpaf_pkg::CMD_POP;
			tpaf_pkg::OP_NACK:  cmd.kind = tpaf_pkg::CMD_RESEND;
			tpaf_pkg::OP_ROUTE: cmd.kind = tpaf_pkg::CMD_ROUTE;
			default:            cmd.kind = tpaf_pkg::CMD_RESEND;
		endcase
	end

endmodule

[hdl/tpaf_cmdq.sv]
// Short command queue between the front end and the ARQ engine.
module tpaf_cmdq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  tpaf_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output tpaf_pkg::cmd_t pop_cmd
);

	tpaf_pkg::cmd_t                  slots_q [tpaf_pkg::CMDQ_DEPTH];
	logic [tpaf_pkg::CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [tpaf_pkg::CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [tpaf_pkg::CMDQ_CNT_W-1:0] count_q;
	logic                            do_push;
	logic                            do_pop;

	function automatic logic [tpaf_pkg::CMDQ_PTR_W-1:0] qptr_inc(
		input logic [tpaf_pkg::CMDQ_PTR_W-1:0] p
	);
		return (p == tpaf_pkg::CMDQ_PTR_W'(tpaf_pkg::CMDQ_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign push_ready = (count_q != tpaf_pkg::CMDQ_CNT_W'(tpaf_pkg::CMDQ_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= qptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= qptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/tpaf_back.sv]
// ARQ engine: retransmit queues of both ports, command execution and the result register.
module tpaf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  tpaf_pkg::cmd_t    cmd,
	output logic              out_valid,
	input  logic              out_ready,
	output tpaf_pkg::result_t result
);

	localparam int SUM_W = tpaf_pkg::FILL_W + 1;

	tpaf_pkg::back_state_t state_q, state_d;
	tpaf_pkg::cmd_t        cmd_q;
	tpaf_pkg::ptr_t        head0_q, head1_q;
	tpaf_pkg::fill_t       fill0_q, fill1_q;
	tpaf_pkg::entry_t      mem0 [tpaf_pkg::QUEUE_DEPTH];
	tpaf_pkg::entry_t      mem1 [tpaf_pkg::QUEUE_DEPTH];
	tpaf_pkg::entry_t      rd0_q, rd1_q;
	tpaf_pkg::result_t     out_q, res1_q;
	logic                  out_valid_q;

	logic                  rd_en;
	tpaf_pkg::ptr_t        rd_addr0, rd_addr1;

	logic                  ap, rp;
	tpaf_pkg::ptr_t        head_ap, head_rp;
	tpaf_pkg::fill_t       fill_ap, fill_rp;
	tpaf_pkg::entry_t      entry_rd, entry_upd;
	logic                  route_full, route_has;
	tpaf_pkg::result_t     route_res;
	logic [SUM_W-1:0]      wsum;
	tpaf_pkg::ptr_t        route_addr;

	logic                  has0, has1;
	tpaf_pkg::result_t     res0, res1;
	logic                  load_ok, commit, load_out, load_second;
	logic                  head_en, fill_en, mem_we, upd_port, mem_port;
	tpaf_pkg::ptr_t        head_val, mem_addr;
	tpaf_pkg::fill_t       fill_val;
	tpaf_pkg::entry_t      mem_data;

	function automatic tpaf_pkg::ptr_t ptr_inc(input tpaf_pkg::ptr_t p);
		return (p == tpaf_pkg::PTR_W'(tpaf_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// The entry is read while the command is taken, so an ACK reads the slot after the head.
	assign rd_en    = (state_q == tpaf_pkg::ST_IDLE) && cmd_valid;
	assign rd_addr0 = (cmd.kind == tpaf_pkg::CMD_POP) ? ptr_inc(head0_q) : head0_q;
	assign rd_addr1 = (cmd.kind == tpaf_pkg::CMD_POP) ? ptr_inc(head1_q) : head1_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd0_q <= mem0[rd_addr0];
			rd1_q <= mem1[rd_addr1];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we && !mem_port) begin
			mem0[mem_addr] <= mem_data;
		end
		if (mem_we && mem_port) begin
			mem1[mem_addr] <= mem_data;
		end
	end

	always_comb begin
		ap       = cmd_q.arrival_port;
		rp       = cmd_q.route_port;
		head_ap  = ap ? head1_q : head0_q;
		fill_ap  = ap ? fill1_q : fill0_q;
		head_rp  = rp ? head1_q : head0_q;
		fill_rp  = rp ? fill1_q : fill0_q;
		entry_rd = ap ? rd1_q : rd0_q;

		entry_upd.tag    = entry_rd.tag;
		entry_upd.errors = tpaf_pkg::sat_inc(entry_rd.errors);
		entry_upd.hops   = tpaf_pkg::sat_inc(entry_rd.hops);

		route_full = (fill_rp == tpaf_pkg::FILL_W'(tpaf_pkg::QUEUE_DEPTH));
		route_has  = route_full || ((fill_rp == '0) && !cmd_q.busy[rp]);
		route_res.port = rp;
		route_res.last = 1'b0;
		if (route_full) begin
			route_res.kind = tpaf_pkg::KIND_DROP;
			route_res.data = cmd_q.pkt;
		end else begin
			route_res.kind        = tpaf_pkg::KIND_DATA;
			route_res.data.tag    = cmd_q.pkt.tag;
			route_res.data.errors = cmd_q.pkt.errors;
			route_res.data.hops   = tpaf_pkg::sat_inc(cmd_q.pkt.hops);
		end

		// Tail slot is head plus fill, wrapped once.
		wsum = SUM_W'(head_rp) + SUM_W'(fill_rp);
		if (wsum >= SUM_W'(tpaf_pkg::QUEUE_DEPTH)) begin
			wsum = wsum - SUM_W'(tpaf_pkg::QUEUE_DEPTH);
		end
		route_addr = wsum[tpaf_pkg::PTR_W-1:0];

		has0     = 1'b0;
		has1     = 1'b0;
		res0     = '0;
		res1     = '0;
		head_en  = 1'b0;
		fill_en  = 1'b0;
		mem_we   = 1'b0;
		upd_port = ap;
		mem_port = ap;
		head_val = head_ap;
		fill_val = fill_ap;
		mem_addr = head_ap;
		mem_data = entry_upd;

		case (cmd_q.kind)
			tpaf_pkg::CMD_NACK_REPLY: begin
				has0      = 1'b1;
				res0.port = ap;
				res0.kind = tpaf_pkg::KIND_NACK;
			end
			tpaf_pkg::CMD_ACK_ROUTE, tpaf_pkg::CMD_ROUTE: begin
				if (cmd_q.kind == tpaf_pkg::CMD_ACK_ROUTE) begin
					has0      = 1'b1;
					res0.port = ap;
					res0.kind = tpaf_pkg::KIND_ACK;
					has1      = route_has;
					res1      = route_res;
				end else begin
					has0 = route_has;
					res0 = route_res;
				end
				upd_port = rp;
				mem_port = rp;
				if (!route_full) begin
					fill_en  = 1'b1;
					fill_val = fill_rp + 1'b1;
					mem_we   = 1'b1;
					mem_addr = route_addr;
					mem_data = cmd_q.pkt;
				end
			end
			tpaf_pkg::CMD_POP: begin
				if (fill_ap != '0) begin
					head_en  = 1'b1;
					head_val = ptr_inc(head_ap);
					fill_en  = 1'b1;
					fill_val = fill_ap - 1'b1;
					if ((fill_ap != tpaf_pkg::FILL_W'(1)) && !cmd_q.busy[ap]) begin
						has0             = 1'b1;
						res0.port        = ap;
						res0.kind        = tpaf_pkg::KIND_DATA;
						res0.data.tag    = entry_rd.tag;
						res0.data.errors = entry_rd.errors;
						res0.data.hops   = tpaf_pkg::sat_inc(entry_rd.hops);
					end
				end
			end
			tpaf_pkg::CMD_RESEND: begin
				if (fill_ap != '0) begin
					mem_we = 1'b1;
					if (!cmd_q.busy[ap]) begin
						has0             = 1'b1;
						res0.port        = ap;
						res0.kind        = tpaf_pkg::KIND_DATA;
						res0.data.tag    = entry_upd.tag;
						res0.data.errors = entry_upd.errors;
						res0.data.hops   = tpaf_pkg::sat_inc(entry_upd.hops);
					end
				end
			end
			default: begin
				has0 = 1'b0;
			end
		endcase
		res0.last = !has1;
		res1.last = 1'b1;

		if (!(state_q == tpaf_pkg::ST_RUN && (!has0 || (!out_valid_q || out_ready)))) begin
			head_en = 1'b0;
			fill_en = 1'b0;
			mem_we  = 1'b0;
		end
	end

	always_comb begin
		load_ok     = !out_valid_q || out_ready;
		commit      = 1'b0;
		load_out    = 1'b0;
		load_second = 1'b0;
		cmd_ready   = 1'b0;
		state_d     = state_q;
		case (state_q)
			tpaf_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					state_d = tpaf_pkg::ST_RUN;
				end
			end
			tpaf_pkg::ST_RUN: begin
				if (!has0 || load_ok) begin
					commit   = 1'b1;
					load_out = has0;
					state_d  = has1 ? tpaf_pkg::ST_SECOND : tpaf_pkg::ST_IDLE;
				end
			end
			tpaf_pkg::ST_SECOND: begin
				if (load_ok) begin
					load_second = 1'b1;
					state_d     = tpaf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tpaf_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpaf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			cmd_q <= cmd;
		end
		if (load_out) begin
			out_q  <= res0;
			res1_q <= res1;
		end else if (load_second) begin
			out_q <= res1_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			head0_q     <= '0;
			head1_q     <= '0;
			fill0_q     <= '0;
			fill1_q     <= '0;
		end else begin
			if (load_out || load_second) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (commit && head_en && !upd_port) begin
				head0_q <= head_val;
			end
			if (commit && head_en && upd_port) begin
				head1_q <= head_val;
			end
			if (commit && fill_en && !upd_port) begin
				fill0_q <= fill_val;
			end
			if (commit && fill_en && upd_port) begin
				fill1_q <= fill_val;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign result    = out_q;

endmodule

[hdl/two_port_arq_forwarder_unit.sv]
// Top level of the two-port stop-and-wait ARQ forwarder.
// The front end takes one item per cycle into a two-entry command queue, so
// in_ready stays high as long as the queue has room. The ARQ engine works on one
// command at a time: its idle state reads the retransmit queue entry of the port, the
// run state updates the queue and loads the first result into the output register,
// and where a clean data packet gives an ACK and a data copy or drop, the second
// state loads the second result. The engine holds whenever it has a result to load,
// the output register is full and out_ready is low. Both retransmit queues come out
// of reset empty through their fill counts; their storage is not cleared.
module two_port_arq_forwarder_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [tpaf_pkg::THR_W-1:0] cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 operation,
	input  logic                       arrival_port,
	input  logic                       bit_error,
	input  logic [15:0]                route_draw,
	input  logic                       busy_port_zero,
	input  logic                       busy_port_one,
	input  logic [15:0]                packet_tag,
	input  logic [7:0]                 packet_errors,
	input  logic [7:0]                 packet_hops,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       out_port,
	output logic [1:0]                 out_kind,
	output logic [15:0]                out_tag,
	output logic [7:0]                 out_errors,
	output logic [7:0]                 out_hops,
	output logic                       last
);

	tpaf_pkg::cmd_t    front_cmd;
	logic              front_valid;
	logic              front_ready;
	tpaf_pkg::cmd_t    q_cmd;
	logic              q_valid;
	logic              q_ready;
	tpaf_pkg::result_t result;

	tpaf_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.arrival_port   (arrival_port),
		.bit_error      (bit_error),
		.route_draw     (route_draw),
		.busy_port_zero (busy_port_zero),
		.busy_port_one  (busy_port_one),
		.packet_tag     (packet_tag),
		.packet_errors  (packet_errors),
		.packet_hops    (packet_hops),
		.cmd_valid      (front_valid),
		.cmd_ready      (front_ready),
		.cmd            (front_cmd)
	);

	tpaf_cmdq u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_cmd   (front_cmd),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_cmd    (q_cmd)
	);

	tpaf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.cmd       (q_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result)
	);

	assign out_port   = result.port;
	assign out_kind   = result.kind;
	assign out_tag    = result.data.tag;
	assign out_errors = result.data.errors;
	assign out_hops   = result.data.hops;
	assign last       = result.last;

	// A first result that is not the last one is always followed at once by the second.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last) |=> out_valid)
		else $error("second result of an item did not follow the first");

	// Only an ACK can be followed by another result of the same item.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> (result.kind == tpaf_pkg::KIND_ACK))
		else $error("non-final result is not an ACK");

	// A NACK reply is the only result of its item.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result.kind == tpaf_pkg::KIND_NACK) |-> last)
		else $error("NACK reply not marked last");

	// The front end stalls only when commands are waiting for the engine.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> q_valid)
		else $error("input stalled with an empty command queue");

endmodule

[sim/two_port_arq_forwarder_unit_tb.sv]
// Self-checking testbench of the two-port ARQ forwarder: directed table, then random traffic.
module two_port_arq_forwarder_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tpaf_pkg::*;

	localparam int SETTLE_CYCLES = 24;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 230;
	localparam int SHOWN_MISMATCHES = 40;

	typedef struct packed {
		op_t         op;
		logic        arrival;
		logic        bit_err;
		logic [15:0] draw;
		logic        busy0;
		logic        busy1;
		entry_t      pkt;
	} arq_item_t;

	typedef struct {
		arq_item_t item;
		int        fixed_count;
		result_t   first;
		result_t   second;
	} stim_row_t;

	localparam result_t NO_RESULT = '0;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [THR_W-1:0]  cfg_wr_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        operation = '0;
	logic              arrival_port = 1'b0;
	logic              bit_error = 1'b0;
	logic [15:0]       route_draw = '0;
	logic              busy_port_zero = 1'b0;
	logic              busy_port_one = 1'b0;
	logic [15:0]       packet_tag = '0;
	logic [7:0]        packet_errors = '0;
	logic [7:0]        packet_hops = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              out_port;
	logic [1:0]        out_kind;
	logic [15:0]       out_tag;
	logic [7:0]        out_errors;
	logic [7:0]        out_hops;
	logic              last;

	// Predictor copy of both retransmit queues and the routing threshold.
	entry_t            q_store [2][QUEUE_DEPTH];
	ptr_t              q_head [2] = '{'0, '0};
	fill_t             q_fill [2] = '{'0, '0};
	logic [THR_W-1:0]  model_threshold = 17'd32768;

	result_t           pending_sends[$];
	result_t           step_results[$];
	stim_row_t         directed_rows[$];
	int                mismatch_count = 0;
	bit                calm = 1'b0;

	two_port_arq_forwarder_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.arrival_port   (arrival_port),
		.bit_error      (bit_error),
		.route_draw     (route_draw),
		.busy_port_zero (busy_port_zero),
		.busy_port_one  (busy_port_one),
		.packet_tag     (packet_tag),
		.packet_errors  (packet_errors),
		.packet_hops    (packet_hops),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_port       (out_port),
		.out_kind       (out_kind),
		.out_tag        (out_tag),
		.out_errors     (out_errors),
		.out_hops       (out_hops),
		.last           (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [7:0] bump_count(input logic [7:0] v);
		return (v == 8'd255) ? 8'd255 : v + 8'd1;
	endfunction

	function automatic void push_result(input logic port, input kind_t kind, input entry_t data);
		result_t r;
		r.port = port;
		r.kind = kind;
		r.data = data;
		r.last = 1'b0;
		step_results.push_back(r);
	endfunction

	function automatic void send_copy(input logic port, input entry_t e, input logic [1:0] busy);
		entry_t c;
		if (!busy[port]) begin
			c = e;
			c.hops = bump_count(e.hops);
			push_result(port, KIND_DATA, c);
		end
	endfunction

	function automatic void route_packet(input logic [15:0] draw, input entry_t e,
			input logic [1:0] busy);
		logic port;
		ptr_t slot;
		port = ({1'b0, draw} < model_threshold) ? 1'b0 : 1'b1;
		if (q_fill[port] >= QUEUE_DEPTH) begin
			push_result(port, KIND_DROP, e);
			return;
		end
		slot = ptr_t'((int'(q_head[port]) + int'(q_fill[port])) % QUEUE_DEPTH);
		q_store[port][slot] = e;
		q_fill[port] = q_fill[port] + 1'b1;
		if (q_fill[port] == 1) begin
			send_copy(port, e, busy);
		end
	endfunction

	function automatic void resend_head(input logic port, input bit add, input logic [1:0] busy);
		if (q_fill[port] == 0) begin
			return;
		end
		if (add) begin
			q_store[port][q_head[port]].errors = bump_count(q_store[port][q_head[port]].errors);
			q_store[port][q_head[port]].hops = bump_count(q_store[port][q_head[port]].hops);
		end
		send_copy(port, q_store[port][q_head[port]], busy);
	endfunction

	// Works out the results of one accepted item into step_results.
	function automatic void predict_forwarding(input arq_item_t it);
		logic [1:0] busy;
		result_t    r;
		step_results.delete();
		busy = {it.busy1, it.busy0};
		case (it.op)
			OP_ROUTE: begin
				route_packet(it.draw, it.pkt, busy);
			end
			OP_DATA: begin
				if (it.bit_err) begin
					push_result(it.arrival, KIND_NACK, '0);
				end else begin
					push_result(it.arrival, KIND_ACK, '0);
					route_packet(it.draw, it.pkt, busy);
				end
			end
			OP_ACK: begin
				if (q_fill[it.arrival] != 0) begin
					q_head[it.arrival] = ptr_t'((int'(q_head[it.arrival]) + 1) % QUEUE_DEPTH);
					q_fill[it.arrival] = q_fill[it.arrival] - 1'b1;
					resend_head(it.arrival, 1'b0, busy);
				end
			end
			default: begin
				resend_head(it.arrival, 1'b1, busy);
			end
		endcase
		if (step_results.size() > 0) begin
			r = step_results.pop_back();
			r.last = 1'b1;
			step_results.push_back(r);
		end
	endfunction

	function automatic arq_item_t make_item(input op_t op, input logic ap, input logic berr,
			input logic [15:0] draw, input logic b0, input logic b1, input logic [15:0] tag,
			input logic [7:0] err, input logic [7:0] hops);
		arq_item_t it;
		it.op = op;
		it.arrival = ap;
		it.bit_err = berr;
		it.draw = draw;
		it.busy0 = b0;
		it.busy1 = b1;
		it.pkt.tag = tag;
		it.pkt.errors = err;
		it.pkt.hops = hops;
		return it;
	endfunction

	function automatic result_t make_result(input logic port, input kind_t kind,
			input logic [15:0] tag, input logic [7:0] err, input logic [7:0] hops, input logic fin);
		result_t r;
		r.port = port;
		r.kind = kind;
		r.data.tag = tag;
		r.data.errors = err;
		r.data.hops = hops;
		r.last = fin;
		return r;
	endfunction

	function automatic void add_row(input arq_item_t it, input int fixed_count,
			input result_t first, input result_t second);
		stim_row_t row;
		row.item = it;
		row.fixed_count = fixed_count;
		row.first = first;
		row.second = second;
		directed_rows.push_back(row);
	endfunction

	function automatic logic [7:0] pick_count();
		if ($urandom_range(4) != 0) begin
			return 8'($urandom);
		end
		case ($urandom_range(2))
			0: return 8'd0;
			1: return 8'd254;
			default: return 8'd255;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		if (mismatch_count < SHOWN_MISMATCHES) begin
			$display("%t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
		end
		mismatch_count++;
	endtask

	task automatic check_result();
		result_t want;
		if (pending_sends.size() == 0) begin
			report_mismatch("unexpected result, tag", out_tag, '0);
			return;
		end
		want = pending_sends.pop_front();
		if (out_port !== want.port) begin
			report_mismatch("out_port", out_port, want.port);
		end
		if (out_kind !== want.kind) begin
			report_mismatch("out_kind", out_kind, want.kind);
		end
		if (out_tag !== want.data.tag) begin
			report_mismatch("out_tag", out_tag, want.data.tag);
		end
		if (out_errors !== want.data.errors) begin
			report_mismatch("out_errors", out_errors, want.data.errors);
		end
		if (out_hops !== want.data.hops) begin
			report_mismatch("out_hops", out_hops, want.data.hops);
		end
		if (last !== want.last) begin
			report_mismatch("last", last, want.last);
		end
	endtask

	// A fixed_count below zero takes the expectations from the predictor.
	task automatic drive_item(input arq_item_t it, input int fixed_count,
			input result_t first, input result_t second);
		int gap;
		gap = 0;
		if (!calm) begin
			while ($urandom_range(99) < 31) begin
				gap++;
			end
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= it.op;
		arrival_port <= it.arrival;
		bit_error <= it.bit_err;
		route_draw <= it.draw;
		busy_port_zero <= it.busy0;
		busy_port_one <= it.busy1;
		packet_tag <= it.pkt.tag;
		packet_errors <= it.pkt.errors;
		packet_hops <= it.pkt.hops;
		do begin
			@(posedge clk);
		end while (!in_ready);
		predict_forwarding(it);
		if (fixed_count < 0) begin
			foreach (step_results[i]) begin
				pending_sends.push_back(step_results[i]);
			end
		end else begin
			if (fixed_count > 0) begin
				pending_sends.push_back(first);
			end
			if (fixed_count > 1) begin
				pending_sends.push_back(second);
			end
		end
	endtask

	task automatic set_threshold(input logic [THR_W-1:0] value);
		in_valid <= 1'b0;
		while (pending_sends.size() != 0) begin
			@(posedge clk);
		end
		// Items that cause no result may still be inside the engine.
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		model_threshold = value;
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			check_result();
		end
		out_ready <= calm || ($urandom_range(99) >= 31);
	end

	initial begin
		arq_item_t        it;
		logic [THR_W-1:0] thr;
		int unsigned      pick;
		bit               filling;

		add_row(make_item(OP_ACK, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 16'h0000, 8'd0, 8'd0),
			0, NO_RESULT, NO_RESULT);
		add_row(make_item(OP_NACK, 1'b1, 1'b0, 16'd0, 1'b0, 1'b0, 16'h0000, 8'd0, 8'd0),
			0, NO_RESULT, NO_RESULT);
		add_row(make_item(OP_DATA, 1'b1, 1'b1, 16'd100, 1'b0, 1'b0, 16'h1234, 8'd7, 8'd9),
			1, make_result(1'b1, KIND_NACK, 16'h0000, 8'd0, 8'd0, 1'b1), NO_RESULT);
		add_row(make_item(OP_DATA, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 16'hFFFF, 8'hFF, 8'hFF),
			2, make_result(1'b0, KIND_ACK, 16'h0000, 8'd0, 8'd0, 1'b0),
			make_result(1'b0, KIND_DATA, 16'hFFFF, 8'hFF, 8'hFF, 1'b1));
		add_row(make_item(OP_ROUTE, 1'b0, 1'b0, 16'd32768, 1'b0, 1'b0, 16'h0000, 8'd0, 8'd0),
			1, make_result(1'b1, KIND_DATA, 16'h0000, 8'd0, 8'd1, 1'b1), NO_RESULT);
		add_row(make_item(OP_ROUTE, 1'b1, 1'b0, 16'd32767, 1'b0, 1'b0, 16'h0101, 8'd3, 8'd4),
			0, NO_RESULT, NO_RESULT);
		// Resending a saturated head keeps both counts at their maximum.
		add_row(make_item(OP_NACK, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 16'h0000, 8'd0, 8'd0),
			1, make_result(1'b0, KIND_DATA, 16'hFFFF, 8'hFF, 8'hFF, 1'b1), NO_RESULT);
		add_row(make_item(OP_ACK, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 16'h0000, 8'd0, 8'd0),
			-1, NO_RESULT, NO_RESULT);
		add_row(make_item(OP_NACK, 1'b0, 1'b0, 16'd0, 1'b1, 1'b0, 16'h0000, 8'd0, 8'd0),
			-1, NO_RESULT, NO_RESULT);
		add_row(make_item(OP_ACK, 1'b1, 1'b0, 16'd0, 1'b0, 1'b0, 16'h0000, 8'd0, 8'd0),
			-1, NO_RESULT, NO_RESULT);
		add_row(make_item(OP_DATA, 1'b1, 1'b0, 16'hFFFF, 1'b0, 1'b1, 16'h5A5A, 8'd0, 8'd0),
			-1, NO_RESULT, NO_RESULT);
		add_row(make_item(OP_NACK, 1'b1, 1'b0, 16'd0, 1'b0, 1'b0, 16'h0000, 8'd0, 8'd0),
			-1, NO_RESULT, NO_RESULT);
		for (int k = 0; k < 7; k++) begin
			add_row(make_item(OP_ROUTE, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 16'h1000 + 16'(k),
				8'(k), 8'(2 * k)), -1, NO_RESULT, NO_RESULT);
		end
		// Port 0 queue is full now, so both routed packets are dropped.
		add_row(make_item(OP_ROUTE, 1'b1, 1'b0, 16'd0, 1'b0, 1'b0, 16'hBEEF, 8'h12, 8'h34),
			1, make_result(1'b0, KIND_DROP, 16'hBEEF, 8'h12, 8'h34, 1'b1), NO_RESULT);
		add_row(make_item(OP_DATA, 1'b1, 1'b0, 16'd0, 1'b0, 1'b0, 16'hCAFE, 8'h00, 8'hFF),
			2, make_result(1'b1, KIND_ACK, 16'h0000, 8'd0, 8'd0, 1'b0),
			make_result(1'b0, KIND_DROP, 16'hCAFE, 8'h00, 8'hFF, 1'b1));
		add_row(make_item(OP_ACK, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 16'h0000, 8'd0, 8'd0),
			-1, NO_RESULT, NO_RESULT);
		add_row(make_item(OP_DATA, 1'b0, 1'b1, 16'd0, 1'b1, 1'b1, 16'h7777, 8'd1, 8'd1),
			1, make_result(1'b0, KIND_NACK, 16'h0000, 8'd0, 8'd0, 1'b1), NO_RESULT);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			drive_item(directed_rows[i].item, directed_rows[i].fixed_count,
				directed_rows[i].first, directed_rows[i].second);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				case (ph)
					1: thr = 17'd0;
					2: thr = 17'd65536;
					3: thr = 17'h1FFFF;
					4: thr = 17'd1;
					5: thr = 17'd65535;
					7: thr = 17'd32768;
					default: thr = 17'($urandom_range(65536));
				endcase
				set_threshold(thr);
			end
			calm = (ph == 3);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Alternate stretches that fill the queues and stretches that drain them.
				filling = ((n / 40) % 2) == 0;
				pick = $urandom_range(99);
				if (filling) begin
					it.op = (pick < 40) ? OP_DATA : (pick < 60) ? OP_ROUTE :
						(pick < 85) ? OP_ACK : OP_NACK;
				end else begin
					it.op = (pick < 15) ? OP_DATA : (pick < 25) ? OP_ROUTE :
						(pick < 75) ? OP_ACK : OP_NACK;
				end
				if ((it.op == OP_ACK || it.op == OP_NACK) && $urandom_range(99) < 85
						&& (q_fill[0] != 0 || q_fill[1] != 0)) begin
					if (q_fill[0] == 0) begin
						it.arrival = 1'b1;
					end else if (q_fill[1] == 0) begin
						it.arrival = 1'b0;
					end else begin
						it.arrival = 1'($urandom_range(1));
					end
				end else begin
					it.arrival = 1'($urandom_range(1));
				end
				it.bit_err = ($urandom_range(99) < 15);
				case ($urandom_range(9))
					0: it.draw = 16'd0;
					1: it.draw = 16'hFFFF;
					2: it.draw = model_threshold[15:0];
					3: it.draw = model_threshold[15:0] - 16'd1;
					default: it.draw = 16'($urandom);
				endcase
				it.busy0 = ($urandom_range(99) < 20);
				it.busy1 = ($urandom_range(99) < 20);
				it.pkt.tag = 16'($urandom);
				it.pkt.errors = pick_count();
				it.pkt.hops = pick_count();
				drive_item(it, -1, NO_RESULT, NO_RESULT);
			end
		end

		in_valid <= 1'b0;
		while (pending_sends.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("two_port_arq_forwarder_unit verification clean");
		end else begin
			$display("two_port_arq_forwarder_unit verification failed");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("two_port_arq_forwarder_unit verification failed");
		$finish;
	end

endmodule
